[rtl/core/gsca_pkg.sv]
// ----------------------------------------------------------------------------
// gsca_pkg : shared types and constants for the gas ppm and climate alert
// Field widths, fixed-point constants, temperature band tables, the stage
// control word and the Q30 root table used by the exponent stages.
// ----------------------------------------------------------------------------
`default_nettype none

package gsca_pkg;

    // defaults for the top-level parameters
    localparam int FULL_SCALE_MV_DEF   = 3300;
    localparam int LOAD_KOHM_DEF       = 47;
    localparam int AGE_TABLE_DEPTH_DEF = 6;

    // field widths
    localparam int MV_W     = 12;
    localparam int TEMP_W   = 11;
    localparam int HUM_W    = 10;
    localparam int R0_W     = 20;
    localparam int AGE_W    = 8;
    localparam int DANGER_W = 16;
    localparam int PPM_W    = 24;

    // datapath widths, sized for the whole parameter range
    localparam int RS_W       = 32;
    localparam int RS_DEN_W   = 12;
    localparam int RATIO_W    = RS_W + 16;
    localparam int MSB_W      = 6;
    localparam int MANT_W     = 31;
    localparam int FRAC_STEPS = 16;
    localparam int LOG_W      = MSB_W + 1 + FRAC_STEPS;

    // fixed-point constants
    localparam logic [RS_W-1:0]    RAIL_RS_Q10   = RS_W'(1024000);
    localparam logic [RATIO_W-1:0] RATIO_MIN_Q16 = RATIO_W'(66);
    localparam int                 CURVE_OFFSET  = 91436;
    localparam int                 CURVE_GAIN    = 249186;
    localparam logic [PPM_W-1:0]   PPM_MAX       = {PPM_W{1'b1}};

    // register map
    localparam int             CFG_ADDR_W = 4;
    localparam logic [1:0]     REG_R0     = 2'd0;
    localparam logic [1:0]     REG_AGE    = 2'd1;
    localparam logic [1:0]     REG_DANGER = 2'd2;
    localparam logic [1:0]     REG_HUMMAX = 2'd3;

    // temperature band by age in weeks, tenths of a degree
    localparam logic signed [11:0] TEMP_MAX_TAB [16] = '{
        12'sd350, 12'sd320, 12'sd290, 12'sd260, 12'sd230, 12'sd220, 12'sd220, 12'sd220,
        12'sd220, 12'sd220, 12'sd220, 12'sd220, 12'sd220, 12'sd220, 12'sd220, 12'sd220};
    localparam logic signed [11:0] TEMP_MIN_TAB [16] = '{
        12'sd320, 12'sd290, 12'sd260, 12'sd230, 12'sd210, 12'sd200, 12'sd200, 12'sd200,
        12'sd200, 12'sd200, 12'sd200, 12'sd200, 12'sd200, 12'sd200, 12'sd200, 12'sd200};

    // control word travelling with each stage
    typedef struct packed {
        logic vld;
        logic rail;
        logic clim_alert;
    } ctl_t;

    typedef logic [MANT_W-1:0] root_tab_t [FRAC_STEPS];

    // integer square root, bit by bit
    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // 2^(2^-(k+1)) in Q30 for entry k, by repeated truncated square roots
    function automatic root_tab_t make_roots();
        root_tab_t   tab;
        logic [63:0] root;
        root = 64'd2 << 30;
        for (int k = 0; k < FRAC_STEPS; k++) begin
            root   = isqrt64(root << 30);
            tab[k] = root[MANT_W-1:0];
        end
        return tab;
    endfunction

    localparam root_tab_t ROOT_Q30 = make_roots();

endpackage

`default_nettype wire

[rtl/core/gas_sensor_ppm_climate_alert.sv]
// ----------------------------------------------------------------------------
// gas_sensor_ppm_climate_alert : gas concentration and climate alert
// Sensor divider voltage to Q8 ppm by a power-law curve, with an alert on
// gas level, humidity and an age-dependent temperature band.
// ----------------------------------------------------------------------------
// Usage
//   s_ channel: one sample word per handshake (divider mV, temperature and
//   humidity in tenths, climate flag in s_tuser). A word with the climate
//   flag low is taken and gives no result.
//   m_ channel: one result word (Q8 ppm in m_tdata, alert in m_tuser).
//   APB port: r0_kohm_q10 at 0x0, age_weeks 0x4, gas_danger_ppm 0x8,
//   humidity_max_tenths 0xC; write only while no word is in flight.
// Pipeline: front stage, divider for resistance, divider for ratio,
//   logarithm, power curve, output register.
// Throughput: one word per cycle unless stalled; every stage is a register stage.
// Reset: clears all valid bits and loads register defaults; words in flight
//   are dropped and no word is produced.
// Stall: while m_tready is low the pipeline keeps moving until a result
//   reaches the last stage behind the held output word, then s_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module gas_sensor_ppm_climate_alert
    import gsca_pkg::*;
#(
    parameter int FULL_SCALE_MV   = FULL_SCALE_MV_DEF,
    parameter int LOAD_KOHM       = LOAD_KOHM_DEF,
    parameter int AGE_TABLE_DEPTH = AGE_TABLE_DEPTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // sample channel
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [39:0]           s_tdata,  // sensor_mv, temperature_tenths, humidity_tenths
    input  wire logic                  s_tuser,  // climate_valid
    // result channel
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [23:0]                m_tdata,  // gas_ppm_q8
    output logic                       m_tuser,  // alert
    // register port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    // configuration registers
    logic [R0_W-1:0]     r0_reg;
    logic [AGE_W-1:0]    age_reg;
    logic [DANGER_W-1:0] danger_reg;
    logic [HUM_W-1:0]    hum_max_reg;
    logic                cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r0_reg      <= R0_W'(10240);
            age_reg     <= AGE_W'(1);
            danger_reg  <= DANGER_W'(25);
            hum_max_reg <= HUM_W'(750);
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_R0:     r0_reg      <= pwdata[R0_W-1:0];
                REG_AGE:    age_reg     <= pwdata[AGE_W-1:0];
                REG_DANGER: danger_reg  <= pwdata[DANGER_W-1:0];
                REG_HUMMAX: hum_max_reg <= pwdata[HUM_W-1:0];
                default:    r0_reg      <= r0_reg;
            endcase
        end
    end

    // register read-back
    always_comb begin
        case (paddr[3:2])
            REG_R0:     prdata = 32'(r0_reg);
            REG_AGE:    prdata = 32'(age_reg);
            REG_DANGER: prdata = 32'(danger_reg);
            REG_HUMMAX: prdata = 32'(hum_max_reg);
            default:    prdata = '0;
        endcase
    end

    // pipeline advance: stall only when a result waits behind a held word
    ctl_t             exp_ctl;
    logic [PPM_W-1:0] exp_ppm;
    logic             en;
    logic             m_tvalid_reg;
    logic [PPM_W-1:0] m_tdata_reg;
    logic             m_tuser_reg;

    assign en       = !exp_ctl.vld || !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // input word unpacking
    logic [MV_W-1:0]          s_mv;
    logic signed [TEMP_W-1:0] s_temp;
    logic [HUM_W-1:0]         s_hum;

    assign s_mv   = s_tdata[MV_W-1:0];
    assign s_temp = $signed(s_tdata[MV_W+TEMP_W-1:MV_W]);
    assign s_hum  = s_tdata[MV_W+TEMP_W+HUM_W-1:MV_W+TEMP_W];

    // temperature band lookup by clamped age
    logic [AGE_W-1:0] age_c;
    logic [3:0]       age_idx;
    logic             clim_alert_c;

    always_comb begin
        if (age_reg == '0) begin
            age_c = AGE_W'(1);
        end else if (age_reg > AGE_W'(AGE_TABLE_DEPTH)) begin
            age_c = AGE_W'(AGE_TABLE_DEPTH);
        end else begin
            age_c = age_reg;
        end
    end

    assign age_idx      = 4'(age_c - AGE_W'(1));
    assign clim_alert_c = (s_hum > hum_max_reg)
                       || (12'(s_temp) > TEMP_MAX_TAB[age_idx])
                       || (12'(s_temp) < TEMP_MIN_TAB[age_idx]);

    // front stage: divider terms and rail detection
    logic                fr_rail;
    ctl_t                fr_ctl_reg;
    logic [RS_W-1:0]     fr_num_reg;
    logic [RS_DEN_W-1:0] fr_den_reg;

    assign fr_rail = (s_mv == '0) || (s_mv >= MV_W'(FULL_SCALE_MV));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fr_ctl_reg <= '0;
        end else if (en) begin
            fr_ctl_reg.vld        <= s_tvalid && s_tuser;
            fr_ctl_reg.rail       <= fr_rail;
            fr_ctl_reg.clim_alert <= clim_alert_c;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fr_num_reg <= (RS_W'(s_mv) * RS_W'(LOAD_KOHM)) << 10;
            fr_den_reg <= fr_rail ? RS_DEN_W'(1) : RS_DEN_W'(FULL_SCALE_MV) - s_mv;
        end
    end

    // sensor resistance in Q10 kOhm
    ctl_t            rs_ctl;
    logic [RS_W-1:0] rs_quo;

    gsca_div #(
        .NUM_W (RS_W),
        .DEN_W (RS_DEN_W)
    ) u_div_rs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_ctl  (fr_ctl_reg),
        .in_num  (fr_num_reg),
        .in_den  (fr_den_reg),
        .out_ctl (rs_ctl),
        .out_quo (rs_quo)
    );

    // resistance ratio in Q16
    logic [RS_W-1:0]    rs_fix;
    logic [R0_W-1:0]    r0_fix;
    ctl_t               ratio_ctl;
    logic [RATIO_W-1:0] ratio_quo;

    assign rs_fix = rs_ctl.rail ? RAIL_RS_Q10 : rs_quo;
    assign r0_fix = (r0_reg == '0) ? R0_W'(1) : r0_reg;

    gsca_div #(
        .NUM_W (RATIO_W),
        .DEN_W (R0_W)
    ) u_div_ratio (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_ctl  (rs_ctl),
        .in_num  ({rs_fix, 16'h0000}),
        .in_den  (r0_fix),
        .out_ctl (ratio_ctl),
        .out_quo (ratio_quo)
    );

    // logarithm of the ratio
    ctl_t                     log_ctl;
    logic signed [LOG_W-1:0]  log_lr;

    gsca_log2 u_log2 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_ctl  (ratio_ctl),
        .in_x    (ratio_quo),
        .out_ctl (log_ctl),
        .out_lr  (log_lr)
    );

    // power curve to Q8 ppm
    gsca_exp2 u_exp2 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_ctl  (log_ctl),
        .in_lr   (log_lr),
        .out_ctl (exp_ctl),
        .out_ppm (exp_ppm)
    );

    // output register with gas threshold
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (exp_ctl.vld && (!m_tvalid_reg || m_tready)) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (exp_ctl.vld && (!m_tvalid_reg || m_tready)) begin
            m_tdata_reg <= exp_ppm;
            m_tuser_reg <= exp_ctl.clim_alert || (exp_ppm >= {danger_reg, 8'h00});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // checks
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !m_tready |=> m_tvalid_reg)
        else $error("result word dropped while stalled");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid_reg && !m_tready && exp_ctl.vld)
        else $error("input stalled without a held result");

    a_gas_alert: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && (m_tdata_reg >= {danger_reg, 8'h00}) |-> m_tuser_reg)
        else $error("gas level over limit without alert");

    a_r0_write: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr && (paddr[3:2] == REG_R0) |=> r0_reg == $past(pwdata[R0_W-1:0]))
        else $error("r0 register write lost");

endmodule

`default_nettype wire

[rtl/core/gsca_div.sv]
// ----------------------------------------------------------------------------
// gsca_div : pipelined restoring divider
// One quotient bit per register stage, MSB first, control word carried along.
// ----------------------------------------------------------------------------
`default_nettype none

module gsca_div
    import gsca_pkg::*;
#(
    parameter int NUM_W = 32,
    parameter int DEN_W = 12
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire ctl_t             in_ctl,
    input  wire logic [NUM_W-1:0] in_num,
    input  wire logic [DEN_W-1:0] in_den,
    output ctl_t                  out_ctl,
    output logic      [NUM_W-1:0] out_quo
);

    ctl_t             ctl_reg [NUM_W];
    logic [NUM_W-1:0] num_reg [NUM_W];
    logic [DEN_W-1:0] den_reg [NUM_W];
    logic [DEN_W-1:0] rem_reg [NUM_W];
    logic [NUM_W-1:0] quo_reg [NUM_W];

    ctl_t             src_ctl [NUM_W];
    logic [NUM_W-1:0] src_num [NUM_W];
    logic [DEN_W-1:0] src_den [NUM_W];
    logic [DEN_W-1:0] src_rem [NUM_W];
    logic [NUM_W-1:0] src_quo [NUM_W];

    for (genvar i = 0; i < NUM_W; i++) begin : g_stage
        logic [DEN_W:0] trial;
        logic [DEN_W:0] diff;
        logic           ge;

        // stage source: the ports for the first stage, else the previous one
        if (i == 0) begin : g_first
            assign src_ctl[i] = in_ctl;
            assign src_num[i] = in_num;
            assign src_den[i] = in_den;
            assign src_rem[i] = '0;
            assign src_quo[i] = '0;
        end else begin : g_next
            assign src_ctl[i] = ctl_reg[i-1];
            assign src_num[i] = num_reg[i-1];
            assign src_den[i] = den_reg[i-1];
            assign src_rem[i] = rem_reg[i-1];
            assign src_quo[i] = quo_reg[i-1];
        end

        // trial subtract of the shifted remainder
        assign trial = {src_rem[i], src_num[i][NUM_W-1]};
        assign diff  = trial - {1'b0, src_den[i]};
        assign ge    = trial >= {1'b0, src_den[i]};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ctl_reg[i] <= '0;
            end else if (en) begin
                ctl_reg[i] <= src_ctl[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                num_reg[i] <= src_num[i] << 1;
                den_reg[i] <= src_den[i];
                rem_reg[i] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                quo_reg[i] <= {src_quo[i][NUM_W-2:0], ge};
            end
        end
    end

    assign out_ctl = ctl_reg[NUM_W-1];
    assign out_quo = quo_reg[NUM_W-1];

endmodule

`default_nettype wire

[rtl/core/gsca_log2.sv]
// ----------------------------------------------------------------------------
// gsca_log2 : pipelined base-2 logarithm, Q16 in and out
// Clamp and leading-one search, normalise, then one squaring per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module gsca_log2
    import gsca_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     en,
    input  wire ctl_t                     in_ctl,
    input  wire logic [RATIO_W-1:0]       in_x,
    output ctl_t                          out_ctl,
    output logic signed [LOG_W-1:0]       out_lr
);

    // leading-one search stage
    logic [RATIO_W-1:0] x_clamp;
    logic [MSB_W-1:0]   msb_c;
    ctl_t               a_ctl_reg;
    logic [RATIO_W-1:0] a_x_reg;
    logic [MSB_W-1:0]   a_msb_reg;

    assign x_clamp = (in_x < RATIO_MIN_Q16) ? RATIO_MIN_Q16 : in_x;

    always_comb begin
        msb_c = '0;
        for (int i = 0; i < RATIO_W; i++) begin
            if (x_clamp[i]) begin
                msb_c = MSB_W'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_ctl_reg <= '0;
        end else if (en) begin
            a_ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_x_reg   <= x_clamp;
            a_msb_reg <= msb_c;
        end
    end

    // normalise to a Q30 mantissa
    logic [RATIO_W-1:0] x_norm;
    ctl_t               b_ctl_reg;
    logic [MANT_W-1:0]  b_mant_reg;
    logic [MSB_W-1:0]   b_msb_reg;

    assign x_norm = a_x_reg << (MSB_W'(RATIO_W - 1) - a_msb_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_ctl_reg <= '0;
        end else if (en) begin
            b_ctl_reg <= a_ctl_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_mant_reg <= x_norm[RATIO_W-1 -: MANT_W];
            b_msb_reg  <= a_msb_reg;
        end
    end

    // squaring stages, one fraction bit each
    ctl_t                  sq_ctl_reg  [FRAC_STEPS];
    logic [MANT_W-1:0]     sq_mant_reg [FRAC_STEPS];
    logic [MSB_W-1:0]      sq_msb_reg  [FRAC_STEPS];
    logic [FRAC_STEPS-1:0] sq_frac_reg [FRAC_STEPS];

    ctl_t                  src_ctl  [FRAC_STEPS];
    logic [MANT_W-1:0]     src_mant [FRAC_STEPS];
    logic [MSB_W-1:0]      src_msb  [FRAC_STEPS];
    logic [FRAC_STEPS-1:0] src_frac [FRAC_STEPS];

    for (genvar k = 0; k < FRAC_STEPS; k++) begin : g_sq
        logic [2*MANT_W-1:0] sq;
        logic [MANT_W:0]     sq_top;

        if (k == 0) begin : g_first
            assign src_ctl[k]  = b_ctl_reg;
            assign src_mant[k] = b_mant_reg;
            assign src_msb[k]  = b_msb_reg;
            assign src_frac[k] = '0;
        end else begin : g_next
            assign src_ctl[k]  = sq_ctl_reg[k-1];
            assign src_mant[k] = sq_mant_reg[k-1];
            assign src_msb[k]  = sq_msb_reg[k-1];
            assign src_frac[k] = sq_frac_reg[k-1];
        end

        assign sq     = src_mant[k] * src_mant[k];
        assign sq_top = sq[2*MANT_W-1:30];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_ctl_reg[k] <= '0;
            end else if (en) begin
                sq_ctl_reg[k] <= src_ctl[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sq_mant_reg[k] <= sq_top[MANT_W] ? sq_top[MANT_W:1] : sq_top[MANT_W-1:0];
                sq_msb_reg[k]  <= src_msb[k];
                sq_frac_reg[k] <= {src_frac[k][FRAC_STEPS-2:0], sq_top[MANT_W]};
            end
        end
    end

    // integer part is the leading-one position less sixteen
    logic [MSB_W:0] int_part;

    assign int_part = {1'b0, sq_msb_reg[FRAC_STEPS-1]} - (MSB_W+1)'(16);
    assign out_ctl  = sq_ctl_reg[FRAC_STEPS-1];
    assign out_lr   = $signed({int_part, sq_frac_reg[FRAC_STEPS-1]});

endmodule

`default_nettype wire

[rtl/core/gsca_exp2.sv]
// ----------------------------------------------------------------------------
// gsca_exp2 : curve scaling and pipelined power of two
// Offset, gain multiply, split into integer and fraction, one root
// multiply per fraction bit, then the final shift and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module gsca_exp2
    import gsca_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     en,
    input  wire ctl_t                     in_ctl,
    input  wire logic signed [LOG_W-1:0]  in_lr,
    output ctl_t                          out_ctl,
    output logic [PPM_W-1:0]              out_ppm
);

    localparam int DIFF_W = LOG_W + 1;
    localparam int GAIN_W = 19;
    localparam int PROD_W = DIFF_W + GAIN_W;
    localparam int Z_W    = PROD_W - 16;

    // curve offset
    ctl_t                     d_ctl_reg;
    logic signed [DIFF_W-1:0] d_diff_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_ctl_reg <= '0;
        end else if (en) begin
            d_ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_diff_reg <= DIFF_W'(CURVE_OFFSET) - DIFF_W'(in_lr);
        end
    end

    // curve gain
    ctl_t                     g_ctl_reg;
    logic signed [PROD_W-1:0] g_prod_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g_ctl_reg <= '0;
        end else if (en) begin
            g_ctl_reg <= d_ctl_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            g_prod_reg <= PROD_W'(d_diff_reg) * PROD_W'($signed(GAIN_W'(CURVE_GAIN)));
        end
    end

    // floor to Q16, add the Q8 output scale, split
    logic signed [Z_W-1:0] z_c;
    ctl_t                  s_ctl_reg;
    logic                  s_sat_reg;
    logic                  s_zero_reg;
    logic [4:0]            s_int_reg;
    logic [15:0]           s_frac_reg;

    assign z_c = g_prod_reg[PROD_W-1:16] + Z_W'(8 * 65536);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s_ctl_reg <= '0;
        end else if (en) begin
            s_ctl_reg <= g_ctl_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s_sat_reg  <= z_c >= Z_W'(24 * 65536);
            s_zero_reg <= z_c[Z_W-1];
            s_int_reg  <= z_c[20:16];
            s_frac_reg <= z_c[15:0];
        end
    end

    // root multiply stages, fraction MSB first
    ctl_t              r_ctl_reg  [FRAC_STEPS];
    logic              r_sat_reg  [FRAC_STEPS];
    logic              r_zero_reg [FRAC_STEPS];
    logic [4:0]        r_int_reg  [FRAC_STEPS];
    logic [15:0]       r_frac_reg [FRAC_STEPS];
    logic [MANT_W-1:0] r_res_reg  [FRAC_STEPS];

    ctl_t              src_ctl  [FRAC_STEPS];
    logic              src_sat  [FRAC_STEPS];
    logic              src_zero [FRAC_STEPS];
    logic [4:0]        src_int  [FRAC_STEPS];
    logic [15:0]       src_frac [FRAC_STEPS];
    logic [MANT_W-1:0] src_res  [FRAC_STEPS];

    for (genvar k = 0; k < FRAC_STEPS; k++) begin : g_root
        logic [2*MANT_W-1:0] prod;

        if (k == 0) begin : g_first
            assign src_ctl[k]  = s_ctl_reg;
            assign src_sat[k]  = s_sat_reg;
            assign src_zero[k] = s_zero_reg;
            assign src_int[k]  = s_int_reg;
            assign src_frac[k] = s_frac_reg;
            assign src_res[k]  = MANT_W'(1) << 30;
        end else begin : g_next
            assign src_ctl[k]  = r_ctl_reg[k-1];
            assign src_sat[k]  = r_sat_reg[k-1];
            assign src_zero[k] = r_zero_reg[k-1];
            assign src_int[k]  = r_int_reg[k-1];
            assign src_frac[k] = r_frac_reg[k-1];
            assign src_res[k]  = r_res_reg[k-1];
        end

        assign prod = src_res[k] * ROOT_Q30[k];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                r_ctl_reg[k] <= '0;
            end else if (en) begin
                r_ctl_reg[k] <= src_ctl[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                r_sat_reg[k]  <= src_sat[k];
                r_zero_reg[k] <= src_zero[k];
                r_int_reg[k]  <= src_int[k];
                r_frac_reg[k] <= src_frac[k];
                r_res_reg[k]  <= src_frac[k][15-k] ? prod[MANT_W+29:30] : src_res[k];
            end
        end
    end

    // final shift by the integer part and saturation
    logic [MANT_W-1:0] res_sh;
    logic [PPM_W-1:0]  ppm_c;
    ctl_t              o_ctl_reg;
    logic [PPM_W-1:0]  o_ppm_reg;

    assign res_sh = r_res_reg[FRAC_STEPS-1] >> (5'd30 - r_int_reg[FRAC_STEPS-1]);

    always_comb begin
        if (r_sat_reg[FRAC_STEPS-1]) begin
            ppm_c = PPM_MAX;
        end else if (r_zero_reg[FRAC_STEPS-1]) begin
            ppm_c = '0;
        end else if (res_sh > MANT_W'(PPM_MAX)) begin
            ppm_c = PPM_MAX;
        end else begin
            ppm_c = res_sh[PPM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_ctl_reg <= '0;
        end else if (en) begin
            o_ctl_reg <= r_ctl_reg[FRAC_STEPS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            o_ppm_reg <= ppm_c;
        end
    end

    assign out_ctl = o_ctl_reg;
    assign out_ppm = o_ppm_reg;

endmodule

`default_nettype wire

[tb/gsca_checker.sv]
// ----------------------------------------------------------------------------
// gsca_checker : result predictor and comparator for the gas alert block
// Watches the sample and result channels, works out the expected Q8 ppm and
// alert for each accepted sample word and compares them in order.
// ----------------------------------------------------------------------------
`default_nettype none

module gsca_checker
    import gsca_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    input  wire logic              s_tready,
    input  wire logic [39:0]       s_tdata,
    input  wire logic              s_tuser,
    input  wire logic              m_tvalid,
    input  wire logic              m_tready,
    input  wire logic [23:0]       m_tdata,
    input  wire logic              m_tuser,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output int                     fail_count,
    output int                     pending_count,
    output int                     result_count
);

    typedef struct packed {
        logic [23:0] ppm;
        logic        alert;
    } alert_word_t;

    alert_word_t expected_words[$];

    logic [19:0] r0_reg;
    logic [7:0]  age_reg;
    logic [15:0] danger_reg;
    logic [9:0]  hummax_reg;

    // integer square root, bit by bit
    function automatic logic [63:0] root64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        while (b > v && b != 0) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint floor_q16(input longint v);
        if (v >= 0) return v / 65536;
        return -((-v + 65535) / 65536);
    endfunction

    // log2 of a Q16 ratio, Q16 result
    function automatic longint log2_ratio(input logic [63:0] x);
        int          p;
        logic [63:0] m;
        longint      frac;
        p = 0;
        frac = 0;
        for (int i = 0; i < 64; i++) if (x[i]) p = i;
        m = (p >= 30) ? (x >> (p - 30)) : (x << (30 - p));
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31)) begin
                frac = frac | 1;
                m = m >> 1;
            end
        end
        return (longint'(p) - 16) * 65536 + frac;
    endfunction

    // 2^(z/65536), saturated to the output width
    function automatic logic [23:0] exp2_ppm(input longint z);
        longint      n;
        longint      f;
        logic [63:0] res;
        logic [63:0] rt;
        longint      sh;
        if (z >= 24 * 65536) return PPM_MAX;
        n = floor_q16(z);
        f = z - n * 65536;
        res = 64'd1 << 30;
        rt = 64'd2 << 30;
        for (int k = 1; k <= 16; k++) begin
            rt = root64(rt << 30);
            if ((f >> (16 - k)) & 1) res = (res * rt) >> 30;
        end
        sh = 30 - n;
        if (sh >= 64) return '0;
        res = res >> sh;
        return (res > 64'hFF_FFFF) ? PPM_MAX : res[23:0];
    endfunction

    function automatic alert_word_t predict_alert(input logic [39:0] d);
        logic [11:0]  mv;
        logic signed [10:0] temp;
        logic [9:0]   hum;
        logic [63:0]  rs;
        logic [63:0]  r0;
        logic [63:0]  ratio;
        longint       lp;
        int           idx;
        alert_word_t  w;
        mv = d[11:0];
        temp = d[22:12];
        hum = d[32:23];
        if (mv == 0 || mv >= FULL_SCALE_MV_DEF) rs = 64'd1024000;
        else rs = (64'(mv) * LOAD_KOHM_DEF * 1024) / (FULL_SCALE_MV_DEF - 64'(mv));
        r0 = (r0_reg == 0) ? 64'd1 : 64'(r0_reg);
        ratio = (rs << 16) / r0;
        if (ratio < 66) ratio = 66;
        lp = floor_q16((longint'(CURVE_OFFSET) - log2_ratio(ratio)) * CURVE_GAIN);
        w.ppm = exp2_ppm(lp + 8 * 65536);
        idx = (age_reg < 1) ? 1 : int'(age_reg);
        if (idx > AGE_TABLE_DEPTH_DEF) idx = AGE_TABLE_DEPTH_DEF;
        idx = idx - 1;
        w.alert = (32'(w.ppm) >= (32'(danger_reg) << 8)) || (hum > hummax_reg)
                  || (int'(temp) > int'(TEMP_MAX_TAB[idx]))
                  || (int'(temp) < int'(TEMP_MIN_TAB[idx]));
        return w;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        fail_count = fail_count + 1;
    endtask

    // register shadow, predictor and comparator
    always @(posedge aclk) begin
        alert_word_t w;
        if (!aresetn) begin
            r0_reg <= 20'd10240;
            age_reg <= 8'd1;
            danger_reg <= 16'd25;
            hummax_reg <= 10'd750;
        end else begin
            if (psel && penable && pwrite) begin
                case (paddr[3:2])
                    REG_R0:     r0_reg <= pwdata[19:0];
                    REG_AGE:    age_reg <= pwdata[7:0];
                    REG_DANGER: danger_reg <= pwdata[15:0];
                    REG_HUMMAX: hummax_reg <= pwdata[9:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready && s_tuser) expected_words.push_back(predict_alert(s_tdata));
            if (m_tvalid && m_tready) begin
                result_count = result_count + 1;
                if (expected_words.size() == 0) begin
                    report_mismatch("unexpected word", int'(m_tdata), -1);
                end else begin
                    w = expected_words.pop_front();
                    if (m_tdata !== w.ppm) report_mismatch("gas_ppm_q8", m_tdata, w.ppm);
                    if (m_tuser !== w.alert) report_mismatch("alert", m_tuser, w.alert);
                end
            end
        end
        pending_count = expected_words.size();
    end

    initial begin
        fail_count = 0;
        pending_count = 0;
        result_count = 0;
    end

endmodule

`default_nettype wire

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top : testbench for the gas ppm and climate alert block
// Directed and random sample words under several register settings, random
// gaps on both channels and one long output hold-off; checker compares.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import gsca_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // sensor_mv, temperature_tenths, humidity_tenths
    logic        s_tuser = 1'b0; // climate_valid
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;        // gas_ppm_q8
    logic        m_tuser;        // alert
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending_count;
    int          result_count;
    int          sent_words = 0;
    bit          hold_done = 1'b0;

    localparam int DRAIN_CYCLES = 200;

    always #1 aclk = ~aclk;

    gas_sensor_ppm_climate_alert dut (.*);

    gsca_checker chk (.*);

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // valid stays high between back-to-back words; it drops only for a gap
    task automatic send_sample(input logic [11:0] mv, input logic [10:0] temp,
                               input logic [9:0] hum, input logic ok, input bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, hum, temp, mv};
        s_tuser <= ok;
        do @(posedge aclk); while (!s_tready);
        sent_words++;
    endtask

    // wait for every result, then DRAIN_CYCLES more to flush words without results
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_count != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic random_samples(input int count);
        logic [11:0] mv;
        logic signed [10:0] temp;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 5))
                0: mv = 12'($urandom_range(0, 4095));
                1: mv = 12'($urandom_range(3290, 4095));
                2: mv = 12'($urandom_range(0, 20));
                default: mv = 12'($urandom_range(1, 3299));
            endcase
            if ($urandom_range(0, 3) == 0) temp = 11'($urandom());
            else temp = 11'($urandom_range(150, 400));
            send_sample(mv, temp, 10'($urandom_range(0, 1023)),
                        $urandom_range(0, 9) != 0, 1'b1);
        end
    endtask

    // receiver with random stalls and one long hold-off
    initial begin
        int g;
        @(posedge aresetn);
        forever begin
            if (!hold_done && sent_words > 300) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
            end
            g = gap_len();
            if (g > 0) begin
                m_tready <= 1'b0;
                repeat (g) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    // stimulus and verdict
    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // directed: rails, field extremes, invalid climate, band edges
        send_sample(12'd0, 11'sd250, 10'd500, 1'b1, 1'b0);
        send_sample(12'd4095, 11'sd250, 10'd500, 1'b1, 1'b0);
        send_sample(12'd3300, -11'sd400, 10'd0, 1'b1, 1'b0);
        send_sample(12'd3299, 11'sd800, 10'd1000, 1'b1, 1'b0);
        send_sample(12'd1, 11'sd320, 10'd750, 1'b1, 1'b0);
        send_sample(12'd1650, 11'sd350, 10'd751, 1'b1, 1'b0);
        send_sample(12'd2000, 11'h7FF, 10'h3FF, 1'b1, 1'b0);
        send_sample(12'd2000, 11'h400, 10'd300, 1'b1, 1'b0);
        send_sample(12'd500, 11'sd330, 10'd300, 1'b0, 1'b0);
        send_sample(12'hFFF, 11'h7FF, 10'h3FF, 1'b0, 1'b0);
        drain();
        // zero R0, deep age, zero gas limit, zero humidity limit
        write_reg(REG_R0, 32'd0);
        write_reg(REG_AGE, 32'd255);
        write_reg(REG_DANGER, 32'd0);
        write_reg(REG_HUMMAX, 32'd0);
        send_sample(12'd0, 11'sd210, 10'd0, 1'b1, 1'b0);
        send_sample(12'd3000, 11'sd220, 10'd0, 1'b1, 1'b0);
        send_sample(12'd1, 11'sd199, 10'd1, 1'b1, 1'b0);
        random_samples(250);
        drain();
        write_reg(REG_R0, 32'hFFFFF);
        write_reg(REG_AGE, 32'd0);
        write_reg(REG_DANGER, 32'd65535);
        write_reg(REG_HUMMAX, 32'd1000);
        send_sample(12'd3299, 11'sd330, 10'd1000, 1'b1, 1'b0);
        send_sample(12'd1, 11'sd300, 10'd1000, 1'b1, 1'b0);
        random_samples(400);
        drain();
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(REG_R0, $urandom_range(1, 200000));
            write_reg(REG_AGE, $urandom_range(0, 8));
            write_reg(REG_DANGER, $urandom_range(0, 2000));
            write_reg(REG_HUMMAX, $urandom_range(0, 1000));
            random_samples(250);
            drain();
        end
        $display("covered %0d sample words, %0d results, seven register settings",
                 sent_words, result_count);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
rtl/core/gsca_pkg.sv
rtl/core/gsca_div.sv
rtl/core/gsca_log2.sv
rtl/core/gsca_exp2.sv
rtl/core/gas_sensor_ppm_climate_alert.sv
tb/gsca_checker.sv
tb/tb_top.sv
